// ===== rtl/s2d_pkg.sv =====
// Package for the signed binary to decimal ASCII converter.
// Holds widths, character codes, the controller state type and the BCD digit adjust.
// Depends on nothing.
`default_nettype none

package s2d_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT    = BIT_CNT_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0]    ALL_DIGITS  = LEFT_W'(NUM_DIGITS);
    localparam logic [LEFT_W-1:0]    ONE_DIGIT   = LEFT_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    // Add three to every BCD digit of five or more, ahead of the next left shift.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0]   res;
        logic [DIGIT_W-1:0] d;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            if (d >= DIGIT_FIVE) begin
                res[i*DIGIT_W +: DIGIT_W] = d + DIGIT_THREE;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/s2d_ifs.sv =====
// Handshake interfaces for the converter: the integer input channel and the text output channel.
// Depends on s2d_pkg for the field widths.
`default_nettype none

interface s2d_num_if
    import s2d_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface s2d_text_if
    import s2d_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/signed_binary_to_decimal_ascii_top.sv =====
// Signed 64-bit integer to decimal ASCII text, bit-serial double-dabble converter.
// Bits are shifted in one by one, leading zeros are dropped, then the sign and the digits are sent.
// Output stalls hold the emission; a new integer is taken only once its last character is loaded.
// The input is taken only while idle; the output register lets the controller run ahead by one item.
// Reset is asynchronous and active low; it returns the controller to idle and empties the output.
// Depends on s2d_pkg and the interfaces in s2d_ifs.sv.
`default_nettype none

module signed_binary_to_decimal_ascii_top
    import s2d_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    s2d_num_if.sink     num,
    s2d_text_if.source  text
);

    state_t               state_reg,   state_next;
    logic [VALUE_W-1:0]   mag_reg,     mag_next;
    logic [BCD_W-1:0]     bcd_reg,     bcd_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [LEFT_W-1:0]    left_reg,    left_next;
    logic                 neg_reg,     neg_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    char_reg,    char_next;
    logic                 last_reg,    last_next;

    logic                 slot_free;
    logic                 load;
    logic [DIGIT_W-1:0]   top_digit;
    logic [BCD_W-1:0]     bcd_adj;

    // The output register can take a new item when it is empty or is being drained.
    assign slot_free = !out_valid_reg || text.ready;
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign bcd_adj   = bcd_adjust(bcd_reg);

    assign num.ready      = (state_reg == ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        left_next    = left_reg;
        neg_next     = neg_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (num.valid)
                begin
                    // Take the magnitude as the two's complement negation for negatives.
                    // The most negative value negates to itself, which read unsigned is 2^63.
                    neg_next     = num.value[VALUE_W-1];
                    mag_next     = num.value[VALUE_W-1] ? (~num.value + VALUE_W'(1))
                                                        : num.value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Double dabble: adjust every digit, then shift one magnitude bit in.
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == LAST_BIT)
                begin
                    left_next  = ALL_DIGITS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, but always keep the final digit.
                if (top_digit == '0 && left_reg != ONE_DIGIT)
                begin
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    char_next = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next = (left_reg == ONE_DIGIT);
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                    if (left_reg == ONE_DIGIT)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (text.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset; the controller qualifies them.
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        left_reg    <= left_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/s2d_checker.sv =====
// Port-level checker for the converter, attached to the top level by a bind statement.
// Depends on s2d_pkg and on signed_binary_to_decimal_ascii_top.
`default_nettype none

module s2d_checker
    import s2d_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              num_ready,
    input wire logic              text_valid,
    input wire logic              text_ready,
    input wire logic [CHAR_W-1:0] text_character,
    input wire logic              text_last
);

    // A stalled output item stays offered.
    a_text_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid)
        else $error("output item withdrawn while stalled");

    // A stalled output item keeps its payload.
    a_text_stable: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> $stable(text_character) && $stable(text_last))
        else $error("output payload changed while stalled");

    // Only a minus sign that is not last, or a digit, is ever shown.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> (text_character == CHAR_MINUS && !text_last) ||
                       (text_character >= CHAR_ZERO && text_character <= CHAR_NINE))
        else $error("illegal output character");

    // No new integer is taken while the text of the current one is unfinished.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_last |-> !num_ready)
        else $error("input accepted before the text was complete");

    // A minus sign is always followed by a digit.
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text_character == CHAR_MINUS
            |=> !(text_valid && text_character == CHAR_MINUS))
        else $error("minus sign not followed by a digit");

endmodule

bind signed_binary_to_decimal_ascii_top s2d_checker u_s2d_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .num_ready      (num.ready),
    .text_valid     (text.valid),
    .text_ready     (text.ready),
    .text_character (text.character),
    .text_last      (text.last)
);

`default_nettype wire
